### hw/rtl/b64enc_pkg.sv
// package: shared types, constants and the symbol lookup for the base64 encoder
`timescale 1ns / 1ps

package b64enc_pkg;

    localparam int unsigned QueueDepth = 2;

    localparam logic [6:0] PadSymbol = 7'h3D;

    // one complete or final partial group as handed from front to back
    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  have_m1;
        logic        last;
    } t_group;

    // queue side seen by the back part
    typedef struct packed {
        logic   valid;
        t_group head;
    } t_queue_out;

    function automatic logic [6:0] sym_of(input logic [5:0] six);
        logic [6:0] r;
        r = 7'd0;
        case (six) inside
            [6'd0:6'd25]:  r = 7'd65 + {1'b0, six};
            [6'd26:6'd51]: r = 7'd71 + {1'b0, six};
            [6'd52:6'd61]: r = {1'b0, six} - 7'd4;
            6'd62:         r = 7'd43;
            6'd63:         r = 7'd47;
            default:       r = PadSymbol;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/b64enc_front.sv
// front part: collects bytes into groups and pushes each finished group
`timescale 1ns / 1ps

module b64enc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_data_byte,
    input  logic                i_end_of_message,
    output logic                o_push,
    output b64enc_pkg::t_group  o_group
);

    logic [1:0] r_count;
    logic [1:0] n_count;
    logic [7:0] r_pend [2];
    logic [7:0] g0;
    logic [7:0] g1;
    logic [7:0] g2;
    logic       full_pair;

    assign full_pair = r_count[1];
    assign o_push    = i_accept && (full_pair || i_end_of_message);

    always_comb begin
        g0 = 8'd0;
        g1 = 8'd0;
        g2 = 8'd0;
        case (r_count)
            2'd0: begin
                g0 = i_data_byte;
            end
            2'd1: begin
                g0 = r_pend[0];
                g1 = i_data_byte;
            end
            default: begin
                g0 = r_pend[0];
                g1 = r_pend[1];
                g2 = i_data_byte;
            end
        endcase
    end

    always_comb begin
        o_group.bits    = {g0, g1, g2};
        o_group.have_m1 = full_pair ? 2'd2 : r_count;
        o_group.last    = i_end_of_message;
    end

    always_comb begin
        n_count = r_count;
        if (o_push) begin
            n_count = 2'd0;
        end else if (i_accept) begin
            n_count = r_count + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && !o_push) begin
            r_pend[r_count[0]] <= i_data_byte;
        end
    end

endmodule

### hw/rtl/b64enc_queue.sv
// short group queue between front and back
`timescale 1ns / 1ps

module b64enc_queue #(
    parameter int unsigned DEPTH = b64enc_pkg::QueueDepth
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  b64enc_pkg::t_group      i_group,
    input  logic                    i_pop,
    output b64enc_pkg::t_queue_out  o_queue,
    output logic                    o_full
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    b64enc_pkg::t_group r_slot [DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_cnt;
    logic [PtrW-1:0] n_wr_ptr;
    logic [PtrW-1:0] n_rd_ptr;
    logic [CntW-1:0] n_cnt;

    assign o_full          = (r_cnt == CntW'(DEPTH));
    assign o_queue.valid   = (r_cnt != '0);
    assign o_queue.head    = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + PtrW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + PtrW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CntW'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_group;
        end
    end

endmodule

### hw/rtl/b64enc_back.sv
// back: queue head to four symbols, one word per cycle unless stalled
`timescale 1ns / 1ps

module b64enc_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  b64enc_pkg::t_queue_out  i_queue,
    output logic                    o_pop,
    input  logic                    i_stall,
    output logic                    o_valid,
    output logic [6:0]              o_symbol,
    output logic                    o_last_symbol
);

    logic [1:0] r_idx;
    logic [1:0] n_idx;
    logic       r_valid;
    logic       n_valid;
    logic [6:0] r_sym;
    logic [6:0] n_sym;
    logic       r_last;
    logic       n_last;
    logic       adv;
    logic       emit;
    logic [5:0] six;
    logic [2:0] have;

    assign adv   = !r_valid || !i_stall;
    assign emit  = adv && i_queue.valid;
    assign o_pop = emit && (r_idx == 2'd3);
    assign have  = {1'b0, i_queue.head.have_m1} + 3'd1;

    always_comb begin
        case (r_idx)
            2'd0:    six = i_queue.head.bits[23:18];
            2'd1:    six = i_queue.head.bits[17:12];
            2'd2:    six = i_queue.head.bits[11:6];
            default: six = i_queue.head.bits[5:0];
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        n_sym   = r_sym;
        n_last  = r_last;
        if (adv) begin
            n_valid = i_queue.valid;
        end
        if (emit) begin
            n_idx  = r_idx + 2'd1;
            n_sym  = ({1'b0, r_idx} > have) ? b64enc_pkg::PadSymbol
                                            : b64enc_pkg::sym_of(six);
            n_last = i_queue.head.last && (r_idx == 2'd3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym  <= n_sym;
        r_last <= n_last;
    end

    assign o_valid       = r_valid;
    assign o_symbol      = r_sym;
    assign o_last_symbol = r_last;

endmodule

### hw/rtl/base64_byte_encoder.sv
// top level: base64 byte encoder, standard alphabet with '=' padding
// a byte that closes a group is written into the queue, then its first symbol is registered
// throughput: one byte a cycle unless the queue is full; four symbols per group, one a cycle
// symbol output waits on i_stall; the single symbol output register sets the sustained rate
// reset: synchronous active low, clears the byte count, queue pointers and output valid
`timescale 1ns / 1ps

module base64_byte_encoder #(
    parameter int unsigned QUEUE_DEPTH = b64enc_pkg::QueueDepth
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_message,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [6:0] o_symbol,
    output logic       o_last_symbol
);

    logic                   accept;
    logic                   push;
    logic                   pop;
    logic                   full;
    b64enc_pkg::t_group     group;
    b64enc_pkg::t_queue_out queue;

    assign o_stall = full;
    assign accept  = i_valid && !full;

    b64enc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .o_push           (push),
        .o_group          (group)
    );

    b64enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_group (group),
        .i_pop   (pop),
        .o_queue (queue),
        .o_full  (full)
    );

    b64enc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_queue       (queue),
        .o_pop         (pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_symbol      (o_symbol),
        .o_last_symbol (o_last_symbol)
    );

endmodule

### hw/rtl/b64enc_checker.sv
// checker: port-level assertions for the base64 encoder, bound to the top level
`timescale 1ns / 1ps

module b64enc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [6:0] o_symbol,
    input logic       o_last_symbol
);

    logic [1:0] r_pos;
    logic       out_word;
    logic       legal;

    assign out_word = o_valid && !i_stall;

    assign legal = ((o_symbol >= 7'd65) && (o_symbol <= 7'd90)) ||
                   ((o_symbol >= 7'd97) && (o_symbol <= 7'd122)) ||
                   ((o_symbol >= 7'd48) && (o_symbol <= 7'd57)) ||
                   (o_symbol == 7'd43) || (o_symbol == 7'd47) ||
                   (o_symbol == b64enc_pkg::PadSymbol);

    // position of the next output word within its group of four
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 2'd0;
        end else if (out_word) begin
            r_pos <= r_pos + 2'd1;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_symbol) && $stable(o_last_symbol))
        else $error("stalled output word changed");

    a_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> legal)
        else $error("output symbol outside the alphabet");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_word && o_last_symbol |-> r_pos == 2'd3)
        else $error("last symbol not at the end of a group");

    a_pad_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_word && (o_symbol == b64enc_pkg::PadSymbol) |-> r_pos[1])
        else $error("padding in the first half of a group");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind base64_byte_encoder b64enc_checker u_b64enc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_symbol      (o_symbol),
    .o_last_symbol (o_last_symbol)
);

### sim/tb_base64_byte_encoder.sv
// testbench: streams byte messages into the base64 encoder and checks each symbol word
`timescale 1ns / 1ps

module tb_base64_byte_encoder;

    localparam int IdleLimit = 1000;

    // one expected symbol word
    typedef struct packed {
        logic [6:0] symbol;
        logic       last;
    } t_exp_symbol;

    // directed row: text is the typed group, zero where the predictor decides
    typedef struct packed {
        logic [7:0]  data;
        logic        eom;
        logic [31:0] text;
    } t_stim_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_end_of_message = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [6:0] o_symbol;
    logic       o_last_symbol;

    string       b64_alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    logic [1:0]  pend_cnt = 2'd0;
    logic [7:0]  pend_bytes [2];
    t_exp_symbol symbol_queue [$];
    int          symbol_errors = 0;
    int          idle_cycles = 0;
    bit          src_calm = 1'b0;
    bit          snk_calm = 1'b0;

    t_stim_row dir_rows [21] = '{
        '{8'h00, 1'b1, "AA=="},
        '{8'hFF, 1'b1, "/w=="},
        '{8'hFF, 1'b0, 32'h0},
        '{8'hFF, 1'b0, 32'h0},
        '{8'hFF, 1'b1, "////"},
        '{8'h00, 1'b0, 32'h0},
        '{8'h00, 1'b0, 32'h0},
        '{8'h00, 1'b0, "AAAA"},
        '{8'hFF, 1'b0, 32'h0},
        '{8'hFF, 1'b1, "//8="},
        '{8'h4D, 1'b0, 32'h0},
        '{8'h61, 1'b0, 32'h0},
        '{8'h6E, 1'b0, 32'h0},
        '{8'hFB, 1'b0, 32'h0},
        '{8'hEF, 1'b0, 32'h0},
        '{8'hBE, 1'b0, 32'h0},
        '{8'h00, 1'b0, 32'h0},
        '{8'h10, 1'b0, 32'h0},
        '{8'h83, 1'b1, 32'h0},
        '{8'h4D, 1'b0, 32'h0},
        '{8'h61, 1'b1, 32'h0}
    };

    base64_byte_encoder u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_symbol         (o_symbol),
        .o_last_symbol    (o_last_symbol)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // wait before a word, with calm stretches that never wait
    function automatic int pick_wait(inout bit calm);
        if ($urandom_range(0, 23) == 0) calm = !calm;
        if (calm) return 0;
        if ($urandom_range(0, 1) == 0) return 0;
        return $urandom_range(0, 17);
    endfunction

    // encoder prediction: returns how many symbols the byte releases
    function automatic int encode_byte(input logic [7:0] b, input logic eom,
                                       output t_exp_symbol [3:0] syms);
        logic [1:0]  cnt;
        logic [23:0] grp;
        logic [5:0]  six;
        byte         ch;
        int          nsym;
        syms = '0;
        cnt = (pend_cnt > 2'd2) ? 2'd2 : pend_cnt;
        if (cnt < 2'd2 && !eom) begin
            pend_bytes[cnt] = b;
            pend_cnt = cnt + 2'd1;
            return 0;
        end
        case (cnt)
            2'd0: begin
                grp = {b, 16'h0000};
            end
            2'd1: begin
                grp = {pend_bytes[0], b, 8'h00};
            end
            default: begin
                grp = {pend_bytes[0], pend_bytes[1], b};
            end
        endcase
        nsym = (cnt == 2'd2) ? 4 : int'(cnt) + 2;
        for (int k = 0; k < 4; k++) begin
            six = grp[23 - 6 * k -: 6];
            ch = b64_alphabet[int'(six)];
            syms[k].symbol = (k < nsym) ? ch[6:0] : b64enc_pkg::PadSymbol;
            syms[k].last = eom && (k == 3);
        end
        pend_cnt = 2'd0;
        return 4;
    endfunction

    task automatic send_byte(input logic [7:0] d, input logic eom, input logic [31:0] text);
        int                gap;
        int                n;
        t_exp_symbol [3:0] grp_syms;
        gap = pick_wait(src_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= d;
        i_end_of_message <= eom;
        do @(posedge i_clk); while (o_stall);
        n = encode_byte(d, eom, grp_syms);
        for (int k = 0; k < n; k++) begin
            if (text != 32'h0) grp_syms[k].symbol = text[30 - 8 * k -: 7];
            symbol_queue = {symbol_queue, grp_syms[k]};
        end
    endtask

    task automatic drain_symbols();
        int          hold;
        t_exp_symbol want;
        forever begin
            hold = pick_wait(snk_calm);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            if (symbol_queue.size() == 0) begin
                $display("%0t: unexpected word symbol %h last %b", $time, o_symbol,
                         o_last_symbol);
                symbol_errors++;
            end else begin
                want = symbol_queue.pop_front();
                if (o_symbol !== want.symbol) begin
                    $display("%0t: symbol expected %h got %h", $time, want.symbol, o_symbol);
                    symbol_errors++;
                end
                if (o_last_symbol !== want.last) begin
                    $display("%0t: last_symbol expected %b got %b", $time, want.last,
                             o_last_symbol);
                    symbol_errors++;
                end
            end
        end
    endtask

    // watchdog on stretches with no word moving
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IdleLimit) begin
                $display("FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int rnd_bytes;
        int len;
        rnd_bytes = 0;
        pend_bytes[0] = 8'h00;
        pend_bytes[1] = 8'h00;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            drain_symbols();
        join_none
        foreach (dir_rows[r]) begin
            send_byte(dir_rows[r].data, dir_rows[r].eom, dir_rows[r].text);
        end
        // random messages, mostly short
        while (rnd_bytes < 300) begin
            if ($urandom_range(0, 7) == 0) len = $urandom_range(9, 30);
            else len = $urandom_range(1, 8);
            for (int j = 0; j < len; j++) begin
                send_byte(8'($urandom_range(0, 255)), j == len - 1, 32'h0);
            end
            rnd_bytes += len;
        end
        i_valid <= 1'b0;
        while (symbol_queue.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (symbol_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
